@@ rtl/pbba_pkg.sv @@
// Package with the constants, codes and helper function of the block allocator.
package pbba_pkg;

  localparam int MAX_BLOCKS = 4096;
  localparam int BIN_COUNT  = 13;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int BIN_W      = $clog2(BIN_COUNT + 1);
  localparam int HINT_W     = BIN_W + 1;
  localparam int PADDR_W    = 3;

  localparam logic [CNT_W-1:0] NIL = CNT_W'(MAX_BLOCKS);

  localparam logic [2:0] OP_INIT     = 3'd0;
  localparam logic [2:0] OP_GET_BLK  = 3'd1;
  localparam logic [2:0] OP_GET_RUN  = 3'd2;
  localparam logic [2:0] OP_FREE_RUN = 3'd3;
  localparam logic [2:0] OP_SWEEP    = 3'd4;
  localparam logic [2:0] OP_CLEAR    = 3'd5;
  localparam logic [2:0] OP_READ     = 3'd6;

  localparam logic [2:0] FLAG_UNSET  = 3'd0;
  localparam logic [2:0] FLAG_FREE   = 3'd1;
  localparam logic [2:0] FLAG_SIMPLE = 3'd2;
  localparam logic [2:0] FLAG_START  = 3'd3;
  localparam logic [2:0] FLAG_MIDDLE = 3'd4;

  // Smallest t with 2^t >= amt; each term is an independent compare.
  function automatic logic [BIN_W-1:0] ceil_log2(input logic [CNT_W-1:0] amt);
    logic [BIN_W-1:0] t;
    t = '0;
    for (int i = 0; i <= CNT_W; i++) begin
      if (((CNT_W+1)'(1) << i) < {1'b0, amt}) begin
        t = BIN_W'(i + 1);
      end
    end
    return t;
  endfunction

endpackage

@@ rtl/power_of_two_binned_block_allocator_core.sv @@
// Top level of the binned block allocator: sequencer, bin lists and metadata memories.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_ready_o   op_i, block_index_i, amount_i
//   out      output     out_valid_o / out_ready_i found_o, result_block_o, meta_flag_o,
//                                                 meta_size_o, free_count_o
//   cfg      input      psel/penable/pwrite       paddr, pwdata, prdata (block_count)
//
// After reset a clearing pass writes every flag and size metadata entry, and no item is
// taken until it ends. Searching the bins looks at one bin at a time and then pops the
// head of the bin found, and a run allocation then marks each block of the run. Filing
// free runs scans the bits of the count and fills each power-of-two piece one block at
// a time through the single flag memory port, then links it into its bin. A waiting
// result does not stop the next item being accepted; only its delivery stalls.
module power_of_two_binned_block_allocator_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   op_i,
  input  logic [pbba_pkg::IDX_W-1:0]   block_index_i,
  input  logic [pbba_pkg::CNT_W-1:0]   amount_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         found_o,
  output logic [pbba_pkg::IDX_W-1:0]   result_block_o,
  output logic [2:0]                   meta_flag_o,
  output logic [pbba_pkg::CNT_W-1:0]   meta_size_o,
  output logic [pbba_pkg::CNT_W-1:0]   free_count_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pbba_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import pbba_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DEC, S_RDWAIT, S_POLL, S_POP, S_FR_CHK, S_FR_BIT,
    S_FILL, S_LINK, S_MARK, S_RESP
  } state_e;

  state_e state_q;

  logic [CNT_W-1:0]  bc_q;
  logic [2:0]        op_q;
  logic [IDX_W-1:0]  bi_q;
  logic [CNT_W-1:0]  amt_q;
  logic [CNT_W-1:0]  cursor_q, limit_q;
  logic [IDX_W-1:0]  pf_q;
  logic [CNT_W-1:0]  pe_q;
  logic              pv_q;
  logic [BIN_W-1:0]  low_q;
  logic signed [HINT_W-1:0] high_q;
  logic [CNT_W-1:0]  ft_q;
  logic [CNT_W-1:0]  head_q [BIN_COUNT];
  logic [CNT_W-1:0]  tail_q [BIN_COUNT];
  logic [BIN_W-1:0]  bin_q;
  logic [IDX_W-1:0]  s_q;
  logic [CNT_W-1:0]  fr_start_q, fr_cnt_q;
  logic [BIN_W-1:0]  fr_bit_q;
  logic [CNT_W-1:0]  k_q;
  logic              r_found_q;
  logic [IDX_W-1:0]  r_res_q;
  logic [2:0]        r_mflag_q;
  logic [CNT_W-1:0]  r_msize_q;
  logic              out_valid_q;
  logic              found_q;
  logic [IDX_W-1:0]  res_q;
  logic [2:0]        mflag_q;
  logic [CNT_W-1:0]  msize_q, fcount_q;

  // Metadata memories with registered read data.
  logic [2:0]        flag_mem [MAX_BLOCKS];
  logic [CNT_W-1:0]  size_mem [MAX_BLOCKS];
  logic [CNT_W-1:0]  link_mem [MAX_BLOCKS];
  logic              flag_we, size_we, link_we;
  logic [IDX_W-1:0]  flag_addr, size_addr, link_addr;
  logic [2:0]        flag_wd, flag_rd_q;
  logic [CNT_W-1:0]  size_wd, size_rd_q, link_wd, link_rd_q;

  logic [BIN_W-1:0]  bin_idx;
  logic [CNT_W-1:0]  head_sel, tail_sel;
  logic              poll_ok;
  logic [CNT_W-1:0]  piece;
  logic [CNT_W-1:0]  nx;
  logic [CNT_W:0]    lim_sum, ft_sum;
  logic [CNT_W-1:0]  clip_cnt;
  logic [BIN_W-1:0]  target, first_bin;
  logic              cfg_wr;

  assign bin_idx  = (bin_q < BIN_W'(BIN_COUNT)) ? bin_q : '0;
  assign head_sel = head_q[bin_idx];
  assign tail_sel = tail_q[bin_idx];
  assign poll_ok  = (bin_q < BIN_W'(BIN_COUNT)) && ($signed({1'b0, bin_q}) <= high_q);
  assign piece    = CNT_W'(1) << fr_bit_q;
  assign nx       = (link_rd_q >= NIL) ? NIL : link_rd_q;
  assign lim_sum  = {2'b00, s_q} + {1'b0, size_rd_q};
  assign clip_cnt = (amt_q > (NIL - {1'b0, bi_q})) ? (NIL - {1'b0, bi_q}) : amt_q;
  assign ft_sum   = {1'b0, ft_q} + {1'b0, clip_cnt};
  assign target   = ceil_log2(amt_q);
  assign first_bin = (low_q > target) ? low_q : target;

  assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == 1'b0);
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == 1'b0) ? {{(32-CNT_W){1'b0}}, bc_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q <= NIL;
    end else if (cfg_wr) begin
      bc_q <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    flag_we = 1'b0; size_we = 1'b0; link_we = 1'b0;
    flag_addr = bi_q; size_addr = bi_q; link_addr = bi_q;
    flag_wd = FLAG_UNSET; size_wd = '0; link_wd = NIL;
    unique case (state_q)
      S_CLR: begin
        flag_we = 1'b1; size_we = 1'b1;
        flag_addr = k_q[IDX_W-1:0]; size_addr = k_q[IDX_W-1:0];
      end
      S_DEC: begin
        if (op_q == OP_GET_BLK && cursor_q < limit_q) begin
          flag_we = 1'b1; flag_addr = cursor_q[IDX_W-1:0]; flag_wd = FLAG_SIMPLE;
        end
      end
      S_POLL: begin
        link_addr = head_sel[IDX_W-1:0];
        size_addr = head_sel[IDX_W-1:0];
      end
      S_POP: begin
        if (op_q == OP_GET_BLK) begin
          flag_we = 1'b1; flag_addr = s_q; flag_wd = FLAG_SIMPLE;
          size_we = 1'b1; size_addr = s_q; size_wd = '0;
        end
      end
      S_FILL: begin
        flag_we = 1'b1; flag_addr = k_q[IDX_W-1:0]; flag_wd = FLAG_FREE;
        if (k_q == fr_start_q) begin
          size_we = 1'b1; size_addr = fr_start_q[IDX_W-1:0]; size_wd = piece;
          link_we = 1'b1; link_addr = fr_start_q[IDX_W-1:0]; link_wd = NIL;
        end
      end
      S_LINK: begin
        if (tail_sel != NIL) begin
          link_we = 1'b1; link_addr = tail_sel[IDX_W-1:0]; link_wd = fr_start_q;
        end
      end
      S_MARK: begin
        flag_we = 1'b1; flag_addr = k_q[IDX_W-1:0];
        if (k_q == {1'b0, s_q}) begin
          flag_wd = FLAG_START;
          size_we = 1'b1; size_addr = s_q; size_wd = amt_q;
        end else begin
          flag_wd = FLAG_MIDDLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (flag_we) flag_mem[flag_addr] <= flag_wd;
    flag_rd_q <= flag_mem[flag_addr];
  end

  always_ff @(posedge clk_i) begin
    if (size_we) size_mem[size_addr] <= size_wd;
    size_rd_q <= size_mem[size_addr];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_addr] <= link_wd;
    link_rd_q <= link_mem[link_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      op_q <= '0; bi_q <= '0; amt_q <= '0;
      cursor_q <= '0; limit_q <= '0;
      pf_q <= '0; pe_q <= '0; pv_q <= 1'b0;
      low_q <= BIN_W'(BIN_COUNT);
      high_q <= -HINT_W'(1);
      ft_q <= '0;
      for (int i = 0; i < BIN_COUNT; i++) begin
        head_q[i] <= NIL;
        tail_q[i] <= NIL;
      end
      bin_q <= '0; s_q <= '0;
      fr_start_q <= '0; fr_cnt_q <= '0; fr_bit_q <= '0;
      k_q <= '0;
      r_found_q <= 1'b0; r_res_q <= '0; r_mflag_q <= '0; r_msize_q <= '0;
      out_valid_q <= 1'b0;
      found_q <= 1'b0; res_q <= '0; mflag_q <= '0; msize_q <= '0; fcount_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_RESP) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLR: begin
          k_q <= k_q + CNT_W'(1);
          if (k_q == NIL - CNT_W'(1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            op_q <= op_i; bi_q <= block_index_i; amt_q <= amount_i;
            r_found_q <= 1'b0; r_res_q <= '0; r_mflag_q <= '0; r_msize_q <= '0;
            state_q <= S_DEC;
          end
        end
        S_DEC: begin
          state_q <= S_RESP;
          case (op_q)
            OP_INIT, OP_CLEAR: begin
              for (int i = 0; i < BIN_COUNT; i++) begin
                head_q[i] <= NIL;
                tail_q[i] <= NIL;
              end
              ft_q <= '0; cursor_q <= '0;
              pf_q <= '0; pe_q <= '0; pv_q <= 1'b0;
              low_q <= BIN_W'(BIN_COUNT);
              high_q <= -HINT_W'(1);
              if (op_q == OP_INIT) begin
                limit_q <= (bc_q > NIL) ? NIL : bc_q;
              end else begin
                limit_q <= '0;
              end
            end
            OP_GET_BLK: begin
              if (cursor_q < limit_q) begin
                r_found_q <= 1'b1;
                r_res_q <= cursor_q[IDX_W-1:0];
                cursor_q <= cursor_q + CNT_W'(1);
              end else begin
                bin_q <= low_q;
                state_q <= S_POLL;
              end
            end
            OP_GET_RUN: begin
              if (amt_q != '0) begin
                if (limit_q > cursor_q && (limit_q - cursor_q) >= amt_q) begin
                  s_q <= cursor_q[IDX_W-1:0];
                  k_q <= cursor_q;
                  cursor_q <= cursor_q + amt_q;
                  r_found_q <= 1'b1;
                  r_res_q <= cursor_q[IDX_W-1:0];
                  state_q <= S_MARK;
                end else begin
                  bin_q <= first_bin;
                  state_q <= S_POLL;
                end
              end
            end
            OP_FREE_RUN: begin
              if (amt_q != '0) begin
                pe_q <= {1'b0, bi_q} + clip_cnt;
                ft_q <= (ft_sum > {1'b0, NIL}) ? NIL : ft_sum[CNT_W-1:0];
                if (!pv_q) begin
                  pv_q <= 1'b1;
                  pf_q <= bi_q;
                end else if (pe_q != {1'b0, bi_q}) begin
                  // A gap: the pending run is filed before the new one starts.
                  fr_start_q <= {1'b0, pf_q};
                  fr_cnt_q <= pe_q - {1'b0, pf_q};
                  pf_q <= bi_q;
                  state_q <= S_FR_CHK;
                end
              end
            end
            OP_SWEEP: begin
              if (pv_q) begin
                fr_start_q <= {1'b0, pf_q};
                fr_cnt_q <= pe_q - {1'b0, pf_q};
                pv_q <= 1'b0; pf_q <= '0; pe_q <= '0;
                state_q <= S_FR_CHK;
              end
            end
            OP_READ: begin
              state_q <= S_RDWAIT;
            end
            default: ;
          endcase
        end
        S_RDWAIT: begin
          r_mflag_q <= flag_rd_q;
          r_msize_q <= size_rd_q;
          state_q <= S_RESP;
        end
        S_POLL: begin
          if (!poll_ok) begin
            state_q <= S_RESP;
          end else if (head_sel == NIL) begin
            low_q <= bin_q + BIN_W'(1);
            bin_q <= bin_q + BIN_W'(1);
          end else begin
            s_q <= head_sel[IDX_W-1:0];
            state_q <= S_POP;
          end
        end
        S_POP: begin
          head_q[bin_idx] <= nx;
          if (nx == NIL) begin
            tail_q[bin_idx] <= NIL;
          end
          r_found_q <= 1'b1;
          r_res_q <= s_q;
          if (op_q == OP_GET_BLK) begin
            cursor_q <= {1'b0, s_q} + CNT_W'(1);
            limit_q <= (lim_sum > {1'b0, NIL}) ? NIL : lim_sum[CNT_W-1:0];
            state_q <= S_RESP;
          end else begin
            k_q <= {1'b0, s_q};
            if (size_rd_q > amt_q) begin
              fr_start_q <= {1'b0, s_q} + amt_q;
              fr_cnt_q <= size_rd_q - amt_q;
              state_q <= S_FR_CHK;
            end else begin
              state_q <= S_MARK;
            end
          end
        end
        S_FR_CHK: begin
          fr_bit_q <= '0;
          if (fr_start_q >= NIL) begin
            k_q <= {1'b0, s_q};
            state_q <= (op_q == OP_GET_RUN) ? S_MARK : S_RESP;
          end else begin
            if (fr_cnt_q > NIL - fr_start_q) begin
              fr_cnt_q <= NIL - fr_start_q;
            end
            state_q <= S_FR_BIT;
          end
        end
        S_FR_BIT: begin
          if (fr_cnt_q == '0) begin
            // The fill loop reuses the block counter, so marking restarts at the run.
            k_q <= {1'b0, s_q};
            state_q <= (op_q == OP_GET_RUN) ? S_MARK : S_RESP;
          end else if (fr_cnt_q[fr_bit_q]) begin
            bin_q <= fr_bit_q;
            k_q <= fr_start_q;
            if (fr_bit_q < low_q) begin
              low_q <= fr_bit_q;
            end
            if ($signed({1'b0, fr_bit_q}) > high_q) begin
              high_q <= HINT_W'(fr_bit_q);
            end
            state_q <= S_FILL;
          end else begin
            fr_bit_q <= fr_bit_q + BIN_W'(1);
          end
        end
        S_FILL: begin
          k_q <= k_q + CNT_W'(1);
          if (k_q + CNT_W'(1) == fr_start_q + piece) begin
            state_q <= S_LINK;
          end
        end
        S_LINK: begin
          if (tail_sel == NIL) begin
            head_q[bin_idx] <= fr_start_q;
          end
          tail_q[bin_idx] <= fr_start_q;
          fr_cnt_q <= fr_cnt_q - piece;
          fr_start_q <= fr_start_q + piece;
          fr_bit_q <= fr_bit_q + BIN_W'(1);
          state_q <= S_FR_BIT;
        end
        S_MARK: begin
          k_q <= k_q + CNT_W'(1);
          if ((k_q + CNT_W'(1) >= {1'b0, s_q} + amt_q) || (k_q + CNT_W'(1) >= NIL)) begin
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            found_q <= r_found_q;
            res_q <= r_res_q;
            mflag_q <= r_mflag_q;
            msize_q <= r_msize_q;
            fcount_q <= ft_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign result_block_o = res_q;
  assign meta_flag_o    = mflag_q;
  assign meta_size_o    = msize_q;
  assign free_count_o   = fcount_q;

endmodule

@@ rtl/pbba_checker.sv @@
// Port-level checker for the block allocator, with its bind to the top level.
module pbba_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         found_o,
  input logic [pbba_pkg::IDX_W-1:0]   result_block_o,
  input logic [2:0]                   meta_flag_o,
  input logic [pbba_pkg::CNT_W-1:0]   meta_size_o,
  input logic [pbba_pkg::CNT_W-1:0]   free_count_o
);
  import pbba_pkg::*;

  // A result that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_block_o)
      && $stable(found_o) && $stable(free_count_o))
    else $error("result item changed while stalled");

  // A failed allocation reports block zero.
  a_nofind_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> result_block_o == '0)
    else $error("result_block set without found");

  // Metadata only comes back from a read, which never allocates.
  a_meta_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> meta_flag_o == FLAG_UNSET && meta_size_o == '0)
    else $error("metadata reported with an allocation");

  // The freed count saturates at the heap size.
  a_free_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> free_count_o <= NIL)
    else $error("free_count above heap size");

  // Ready does not stay high after an item is accepted; the next waits for the return to idle.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready held after accepting an item");

endmodule

bind power_of_two_binned_block_allocator_core pbba_checker u_pbba_checker (.*);

@@ bench/tb_top.sv @@
// Self-checking testbench for the power-of-two binned block allocator core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pbba_pkg::*;

  localparam logic [2:0] OP_NOP = 3'd7;
  localparam logic [PADDR_W-1:0] ADDR_BLOCK_COUNT = '0;
  localparam int NO_BLOCK = MAX_BLOCKS;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] blk;
    logic [2:0]       mflag;
    logic [CNT_W-1:0] msize;
    logic [CNT_W-1:0] fcount;
  } alloc_result_t;

  // Holds the expected results in order and compares each delivered item.
  class alloc_scoreboard;
    alloc_result_t expected_q[$];

    function void note_item(alloc_result_t r);
      expected_q.push_back(r);
    endfunction

    function int check_result(alloc_result_t got, output string why);
      alloc_result_t e;
      int bad;
      bad = 0;
      why = "";
      if (expected_q.size() == 0) begin
        why = "result delivered with nothing expected";
        return 1;
      end
      e = expected_q.pop_front();
      if (got.found !== e.found) begin
        bad++;
        why = {why, $sformatf(" found %0d/%0d", got.found, e.found)};
      end
      if (got.blk !== e.blk) begin
        bad++;
        why = {why, $sformatf(" block %0d/%0d", got.blk, e.blk)};
      end
      if (got.mflag !== e.mflag) begin
        bad++;
        why = {why, $sformatf(" flag %0d/%0d", got.mflag, e.mflag)};
      end
      if (got.msize !== e.msize) begin
        bad++;
        why = {why, $sformatf(" size %0d/%0d", got.msize, e.msize)};
      end
      if (got.fcount !== e.fcount) begin
        bad++;
        why = {why, $sformatf(" freed %0d/%0d", got.fcount, e.fcount)};
      end
      return bad;
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [2:0]       op_i = OP_NOP;
  logic [IDX_W-1:0] block_index_i = '0;
  logic [CNT_W-1:0] amount_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic             found_o;
  logic [IDX_W-1:0] result_block_o;
  logic [2:0]       meta_flag_o;
  logic [CNT_W-1:0] meta_size_o;
  logic [CNT_W-1:0] free_count_o;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  power_of_two_binned_block_allocator_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .block_index_i, .amount_i,
    .out_valid_o, .out_ready_i, .found_o, .result_block_o, .meta_flag_o,
    .meta_size_o, .free_count_o, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready
  );

  always #1 clk_i = ~clk_i;

  alloc_scoreboard sb = new();
  int errors = 0;
  bit hold_req = 1'b0;
  bit gaps_on = 1'b1;

  // Predictor state.
  logic [2:0] flg [MAX_BLOCKS];
  int rsz [MAX_BLOCKS];
  int nxt [MAX_BLOCKS];
  int bhead [BIN_COUNT];
  int btail [BIN_COUNT];
  int bcur, blim, pfirst, pend, lowh, highh, freed, bcount;
  bit pval;

  function automatic void reset_bins();
    for (int i = 0; i < BIN_COUNT; i++) begin
      bhead[i] = NO_BLOCK;
      btail[i] = NO_BLOCK;
    end
    freed = 0;
    bcur = 0;
    blim = 0;
    pfirst = 0;
    pend = 0;
    pval = 1'b0;
    lowh = BIN_COUNT;
    highh = -1;
  endfunction

  function automatic int take_from_bin(int b);
    int h, nx;
    h = bhead[b];
    if (h >= NO_BLOCK) return NO_BLOCK;
    nx = nxt[h];
    if (nx >= NO_BLOCK) nx = NO_BLOCK;
    bhead[b] = nx;
    if (nx == NO_BLOCK) btail[b] = NO_BLOCK;
    return h;
  endfunction

  function automatic int search_bins(int first);
    int s;
    for (int i = first; i <= highh && i < BIN_COUNT; i++) begin
      s = take_from_bin(i);
      if (s != NO_BLOCK) return s;
      lowh = i + 1;
    end
    return NO_BLOCK;
  endfunction

  // Splits a free run into power-of-two pieces, smallest first, and files each one.
  function automatic void place_run(int start, int count);
    int b, p;
    if (start >= MAX_BLOCKS) return;
    if (count > MAX_BLOCKS - start) count = MAX_BLOCKS - start;
    for (int bit_i = 0; bit_i < 31 && count > 0; bit_i++) begin
      p = 1 << bit_i;
      if ((count & p) != 0) begin
        b = (bit_i >= BIN_COUNT) ? BIN_COUNT - 1 : bit_i;
        if (b < lowh) lowh = b;
        if (b > highh) highh = b;
        for (int k = start; k < start + p && k < MAX_BLOCKS; k++) flg[k] = FLAG_FREE;
        rsz[start] = p & 'h1FFF;
        nxt[start] = NO_BLOCK;
        if (btail[b] < NO_BLOCK) nxt[btail[b]] = start;
        else bhead[b] = start;
        btail[b] = start;
        count -= p;
        start += p;
      end
    end
  endfunction

  function automatic alloc_result_t predict_alloc(logic [2:0] op, int bi, int amt);
    alloc_result_t r;
    int s, lim_v, target, first, have, c;
    r = '0;
    case (op)
      OP_INIT: begin
        reset_bins();
        blim = (bcount < MAX_BLOCKS) ? bcount : MAX_BLOCKS;
      end
      OP_GET_BLK: begin
        if (bcur >= blim) begin
          s = search_bins(lowh);
          if (s != NO_BLOCK) begin
            lim_v = s + rsz[s];
            if (lim_v > MAX_BLOCKS) lim_v = MAX_BLOCKS;
            bcur = s + 1;
            blim = lim_v;
            rsz[s] = 0;
            flg[s] = FLAG_SIMPLE;
            r.found = 1'b1;
            r.blk = IDX_W'(s);
          end
        end else begin
          r.blk = IDX_W'(bcur);
          flg[bcur] = FLAG_SIMPLE;
          bcur++;
          r.found = 1'b1;
        end
      end
      OP_GET_RUN: begin
        if (amt != 0) begin
          s = NO_BLOCK;
          if (blim > bcur && blim - bcur >= amt) begin
            s = bcur;
            bcur += amt;
          end else begin
            target = 0;
            while (target < 31 && (1 << target) < amt) target++;
            first = (lowh > target) ? lowh : target;
            s = search_bins(first);
            if (s != NO_BLOCK) begin
              have = rsz[s];
              if (have > amt) place_run(s + amt, have - amt);
            end
          end
          if (s != NO_BLOCK) begin
            flg[s] = FLAG_START;
            rsz[s] = amt;
            for (int k = s + 1; k < s + amt && k < MAX_BLOCKS; k++) flg[k] = FLAG_MIDDLE;
            r.found = 1'b1;
            r.blk = IDX_W'(s);
          end
        end
      end
      OP_FREE_RUN: begin
        if (amt != 0) begin
          c = (amt > MAX_BLOCKS - bi) ? MAX_BLOCKS - bi : amt;
          if (!pval) begin
            pval = 1'b1;
            pfirst = bi;
          end else if (pend != bi) begin
            place_run(pfirst, pend - pfirst);
            pfirst = bi;
          end
          pend = bi + c;
          freed += c;
          if (freed > MAX_BLOCKS) freed = MAX_BLOCKS;
        end
      end
      OP_SWEEP: begin
        if (pval) begin
          place_run(pfirst, pend - pfirst);
          pval = 1'b0;
          pfirst = 0;
          pend = 0;
        end
      end
      OP_CLEAR: reset_bins();
      OP_READ: begin
        r.mflag = flg[bi];
        r.msize = CNT_W'(rsz[bi]);
      end
      default: ;
    endcase
    r.fcount = CNT_W'(freed);
    return r;
  endfunction

  task automatic report_mismatch(string why);
    errors++;
    $display("mismatch at %0t:%s", $realtime, why);
  endtask

  // Offers one item and holds it until it is taken; the caller decides on gaps.
  task automatic send_item(logic [2:0] op, int bi, int amt);
    in_valid_i <= 1'b1;
    op_i <= op;
    block_index_i <= bi[IDX_W-1:0];
    amount_i <= amt[CNT_W-1:0];
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(predict_alloc(op, bi, amt));
  endtask

  int burst_left = 0;

  task automatic issue(logic [2:0] op, int bi, int amt);
    int gap;
    send_item(op, bi, amt);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 20);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic write_block_count(int v);
    in_valid_i <= 1'b0;
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_BLOCK_COUNT;
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    bcount = v & 'h1FFF;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    // A short quiet spell separates the last item from the register write.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic int pick_amount();
    int w;
    w = $urandom_range(0, 99);
    if (w < 80) return $urandom_range(1, 16);
    if (w < 95) return $urandom_range(1, 256);
    if (w < 98) return $urandom_range(1, MAX_BLOCKS);
    return $urandom_range(0, (1 << CNT_W) - 1);
  endfunction

  task automatic random_phase(int count);
    int w, bi, amt, chain;
    chain = 0;
    for (int n = 0; n < count; n++) begin
      w = $urandom_range(0, 99);
      amt = pick_amount();
      bi = $urandom_range(0, MAX_BLOCKS - 1);
      if (w < 2) begin
        issue(OP_INIT, bi, amt);
      end else if (w < 4) begin
        issue(OP_CLEAR, bi, amt);
      end else if (w < 6) begin
        issue(OP_NOP, bi, amt);
      end else if (w < 30) begin
        issue(OP_GET_BLK, bi, amt);
      end else if (w < 50) begin
        issue(OP_GET_RUN, bi, amt);
      end else if (w < 75) begin
        // Mostly address-ordered frees so that runs coalesce.
        if ($urandom_range(0, 9) < 7 && chain < MAX_BLOCKS) bi = chain;
        else if ($urandom_range(0, 3) != 0) bi = $urandom_range(0, bcount + 8) % MAX_BLOCKS;
        if ($urandom_range(0, 3) != 0) amt = $urandom_range(1, 16);
        issue(OP_FREE_RUN, bi, amt);
        chain = bi + amt;
      end else if (w < 84) begin
        issue(OP_SWEEP, bi, amt);
        chain = $urandom_range(0, bcount) % MAX_BLOCKS;
      end else begin
        if ($urandom_range(0, 3) != 0) bi = $urandom_range(0, bcount + 8) % MAX_BLOCKS;
        issue(OP_READ, bi, amt);
      end
      if (n == count / 2 && !hold_req && $urandom_range(0, 1) == 1) hold_req = 1'b1;
    end
  endtask

  // Receiver: stalls on a pattern picked at random from three, plus long hold-offs.
  initial begin
    int mode, tick, hold;
    mode = 0;
    tick = 0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (tick % 64 == 0) mode = $urandom_range(0, 2);
      if (hold_req && hold == 0) begin
        hold = 600;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 1) == 1);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    alloc_result_t got;
    string why;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{found_o, result_block_o, meta_flag_o, meta_size_o, free_count_o};
      if (sb.check_result(got, why) != 0) report_mismatch(why);
    end
  end

  initial begin
    #10ms;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    int settings [5] = '{1, 64, 300, MAX_BLOCKS - 1, MAX_BLOCKS};
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      flg[i] = FLAG_UNSET;
      rsz[i] = 0;
      nxt[i] = 0;
    end
    reset_bins();
    bcount = MAX_BLOCKS;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the reset setting of block_count.
    issue(OP_GET_BLK, 0, 1);
    issue(OP_READ, 0, 0);
    issue(OP_READ, MAX_BLOCKS - 1, 0);
    issue(OP_INIT, 0, 0);
    issue(OP_GET_BLK, 0, 0);
    issue(OP_GET_RUN, 0, 1);
    issue(OP_GET_RUN, 0, MAX_BLOCKS);
    issue(OP_GET_RUN, 0, 0);
    issue(OP_GET_RUN, MAX_BLOCKS - 1, (1 << CNT_W) - 1);
    issue(OP_FREE_RUN, MAX_BLOCKS - 1, (1 << CNT_W) - 1);
    issue(OP_FREE_RUN, 0, 1);
    issue(OP_FREE_RUN, 1, 2);
    issue(OP_FREE_RUN, 10, 3);
    issue(OP_FREE_RUN, 20, 0);
    issue(OP_SWEEP, 0, 0);
    issue(OP_GET_BLK, 0, 0);
    issue(OP_GET_RUN, 0, 3);
    issue(OP_READ, 10, 0);
    issue(OP_FREE_RUN, 0, MAX_BLOCKS);
    issue(OP_FREE_RUN, 0, MAX_BLOCKS);
    issue(OP_SWEEP, 0, 0);
    issue(OP_GET_RUN, 0, MAX_BLOCKS);
    issue(OP_NOP, MAX_BLOCKS - 1, (1 << CNT_W) - 1);
    issue(OP_CLEAR, 0, 0);
    issue(OP_GET_BLK, 0, 0);

    hold_req = 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      write_block_count(ph < 5 ? settings[ph] : $urandom_range(1, MAX_BLOCKS));
      @(posedge clk_i);
      gaps_on = (ph != 2);
      issue(OP_INIT, 0, 0);
      random_phase(300);
    end

    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
